>>> design/gbmps_pkg.sv
// gbmps_pkg: shared widths, limits, state type and Horner coefficients
// for the GBM path price simulator. No dependencies.
`default_nettype none

package gbmps_pkg;

    // Field and datapath widths
    localparam int PRICE_W    = 40;
    localparam int SUM_W      = 60;
    localparam int Z_W        = 16;
    localparam int Z_FRAC     = 12;
    localparam int VOL_W      = 31;
    localparam int DRIFT_W    = 32;
    localparam int DAYS_W     = 13;
    localparam int PATHS_W    = 21;
    localparam int Q_FRAC     = 30;
    localparam int X_W        = 36;
    localparam int RES_W      = 48;
    localparam int OPD_W      = 48;
    localparam int HALF_W     = OPD_W / 2;
    localparam int PROD_W     = 2 * OPD_W;

    // Run limits
    localparam int MAX_DAYS   = 4096;
    localparam int MAX_PATHS  = 1048576;
    localparam int DAY_CNT_W  = $clog2(MAX_DAYS);
    localparam int PATH_CNT_W = $clog2(MAX_PATHS);

    localparam logic [PRICE_W-1:0]   PRICE_MAX = {PRICE_W{1'b1}};
    localparam logic [SUM_W-1:0]     SUM_MAX   = {SUM_W{1'b1}};
    localparam logic signed [X_W-1:0] EXP_LIMIT = 36'sd17179869184;  // 16.0 in Q.30

    // APB register map, index = paddr[5:3]
    localparam int APB_AW = 6;
    localparam logic [2:0] REG_START_PRICE = 3'd0;
    localparam logic [2:0] REG_DRIFT       = 3'd1;
    localparam logic [2:0] REG_VOL         = 3'd2;
    localparam logic [2:0] REG_DAYS        = 3'd3;
    localparam logic [2:0] REG_PATHS       = 3'd4;

    // Per-day operation slots of the shared multiplier
    localparam logic [2:0] OP_EXPONENT    = 3'd0;
    localparam logic [2:0] OP_LAST_HORNER = 3'd6;
    localparam logic [2:0] OP_PRICE       = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DAY_END,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    // Horner coefficients in Q.30: 1/720, 1/120, 1/24, 1/6, 1/2, then 1.0
    function automatic logic signed [RES_W-1:0] horner_coef(input logic [2:0] k);
        logic signed [RES_W-1:0] c;
        case (k)
            3'd0:    c = 48'sd1491308;
            3'd1:    c = 48'sd8947849;
            3'd2:    c = 48'sd44739243;
            3'd3:    c = 48'sd178956971;
            3'd4:    c = 48'sd536870912;
            default: c = 48'sd1073741824;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/gbmps_mul.sv
// gbmps_mul: 48x48 unsigned multiplier built from four 24x24 partial
// products. Depends on gbmps_pkg.
`default_nettype none

module gbmps_mul import gbmps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [OPD_W-1:0]  i_a,
    input  wire logic [OPD_W-1:0]  i_b,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);

    logic              r_busy, n_busy;
    logic [2:0]        r_cnt, n_cnt;
    logic [OPD_W-1:0]  r_a, n_a, r_b, n_b;
    logic [2*HALF_W-1:0] r_pp, n_pp;
    logic [1:0]        r_pp_idx, n_pp_idx;
    logic              r_pp_vld, n_pp_vld;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic              r_done, n_done;

    logic [HALF_W-1:0] w_a_half, w_b_half;
    logic [1:0]        w_sh;
    logic [PROD_W-1:0] w_pp_ext, w_pp_shift;

    // operand halves picked by the slot counter
    assign w_a_half = r_cnt[0] ? r_a[OPD_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign w_b_half = r_cnt[1] ? r_b[OPD_W-1:HALF_W] : r_b[HALF_W-1:0];

    // align the registered partial product
    assign w_sh       = {1'b0, r_pp_idx[0]} + {1'b0, r_pp_idx[1]};
    assign w_pp_ext   = {{(PROD_W-2*HALF_W){1'b0}}, r_pp};
    assign w_pp_shift = w_pp_ext << (HALF_W * w_sh);

    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_a      = r_a;
        n_b      = r_b;
        n_pp     = r_pp;
        n_pp_idx = r_pp_idx;
        n_pp_vld = 1'b0;
        n_acc    = r_acc;
        n_done   = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_cnt  = 3'd0;
                n_a    = i_a;
                n_b    = i_b;
                n_acc  = '0;
            end
        end else begin
            if (r_cnt < 3'd4) begin
                n_pp     = w_a_half * w_b_half;
                n_pp_idx = r_cnt[1:0];
                n_pp_vld = 1'b1;
            end
            if (r_pp_vld) begin
                n_acc = r_acc + w_pp_shift;
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd4) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= 3'd0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_pp_vld <= n_pp_vld;
            r_done   <= n_done;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_pp     <= n_pp;
        r_pp_idx <= n_pp_idx;
        r_acc    <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

>>> design/gbmps_div.sv
// gbmps_div: restoring divider, one quotient bit per cycle, for the
// mean of final prices. Depends on gbmps_pkg.
`default_nettype none

module gbmps_div import gbmps_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [SUM_W-1:0]   i_dividend,
    input  wire logic [PATHS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [SUM_W-1:0]        o_quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_quo, n_quo;
    logic [PATHS_W-1:0] r_rem, n_rem;
    logic [PATHS_W-1:0] r_dvs, n_dvs;
    logic               r_done, n_done;

    logic [PATHS_W:0]   w_trial;
    logic               w_fit;

    // shift in the next dividend bit and test against the divisor
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_quo  = i_dividend;
                n_rem  = '0;
                n_dvs  = i_divisor;
            end
        end else begin
            if (w_fit) begin
                n_rem = PATHS_W'(w_trial - {1'b0, r_dvs});
            end else begin
                n_rem = w_trial[PATHS_W-1:0];
            end
            n_quo = {r_quo[SUM_W-2:0], w_fit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> design/gbm_path_price_simulator.sv
// gbm_path_price_simulator: top level, GBM price path with exp by Horner.
// Depends on gbmps_pkg, gbmps_mul, gbmps_div.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  sample   | in        | i_in_valid / o_in_stall  | i_normal_sample
//  result   | out       | o_out_valid / i_out_stall| o_final_price, o_lowest_price,
//           |           |                          | o_highest_price, o_mean_price,
//           |           |                          | o_run_done
//  config   | in        | APB psel/penable/pready  | paddr, pwdata, prdata
//
// Each sample runs eight products (exponent, six Horner steps, price update)
// one after another on the shared 48x48 multiplier, which builds each product
// from four 24x24 partial products. A run end also runs the bit-serial mean divider.
// Reset is synchronous, active low; control and configuration registers return to
// their reset values, while datapath and result payload registers are not reset.
// A stalled result is held in the output register while the next sample is
// taken; the sequencer waits only if a new result is ready before it drains.
`default_nettype none

module gbm_path_price_simulator import gbmps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sample channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic signed [Z_W-1:0] i_normal_sample,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PRICE_W-1:0]         o_final_price,
    output logic [PRICE_W-1:0]         o_lowest_price,
    output logic [PRICE_W-1:0]         o_highest_price,
    output logic [PRICE_W-1:0]         o_mean_price,
    output logic                       o_run_done,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);

    // ---------------- configuration registers ----------------
    logic [PRICE_W-1:0]        r_start_price;
    logic signed [DRIFT_W-1:0] r_drift;
    logic [VOL_W-1:0]          r_vol;
    logic [DAYS_W-1:0]         r_days;
    logic [PATHS_W-1:0]        r_paths;

    logic       w_cfg_wr;
    logic [2:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[APB_AW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_price <= PRICE_W'(1048576);
            r_drift       <= '0;
            r_vol         <= '0;
            r_days        <= DAYS_W'(1);
            r_paths       <= PATHS_W'(1);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_START_PRICE: r_start_price <= pwdata[PRICE_W-1:0];
                REG_DRIFT:       r_drift       <= $signed(pwdata[DRIFT_W-1:0]);
                REG_VOL:         r_vol         <= pwdata[VOL_W-1:0];
                REG_DAYS:        r_days        <= pwdata[DAYS_W-1:0];
                REG_PATHS:       r_paths       <= pwdata[PATHS_W-1:0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            REG_START_PRICE: prdata = {{(64-PRICE_W){1'b0}}, r_start_price};
            REG_DRIFT:       prdata = {{(64-DRIFT_W){1'b0}}, r_drift};
            REG_VOL:         prdata = {{(64-VOL_W){1'b0}}, r_vol};
            REG_DAYS:        prdata = {{(64-DAYS_W){1'b0}}, r_days};
            REG_PATHS:       prdata = {{(64-PATHS_W){1'b0}}, r_paths};
            default:         prdata = '0;
        endcase
    end

    // clamped lengths: zero acts as one, large values act as the maximum
    logic [DAYS_W-1:0]  w_days_c;
    logic [PATHS_W-1:0] w_paths_c;

    always_comb begin
        if (r_days == '0) begin
            w_days_c = DAYS_W'(1);
        end else if (r_days > DAYS_W'(MAX_DAYS)) begin
            w_days_c = DAYS_W'(MAX_DAYS);
        end else begin
            w_days_c = r_days;
        end
        if (r_paths == '0) begin
            w_paths_c = PATHS_W'(1);
        end else if (r_paths > PATHS_W'(MAX_PATHS)) begin
            w_paths_c = PATHS_W'(MAX_PATHS);
        end else begin
            w_paths_c = r_paths;
        end
    end

    // ---------------- sequencer and datapath state ----------------
    t_state                  r_state, n_state;
    logic [2:0]              r_op, n_op;
    logic [Z_W-1:0]          r_zmag, n_zmag;
    logic                    r_zneg, n_zneg;
    logic signed [X_W-1:0]   r_x, n_x;
    logic signed [RES_W-1:0] r_res, n_res;
    logic [PRICE_W-1:0]      r_price, n_price;
    logic [DAY_CNT_W-1:0]    r_day, n_day;
    logic [PATH_CNT_W-1:0]   r_path, n_path;
    logic [PRICE_W-1:0]      r_min, n_min;
    logic [PRICE_W-1:0]      r_max, n_max;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic                    r_run_end, n_run_end;

    logic                    r_out_valid, n_out_valid;
    logic [PRICE_W-1:0]      r_out_final, n_out_final;
    logic [PRICE_W-1:0]      r_out_low, n_out_low;
    logic [PRICE_W-1:0]      r_out_high, n_out_high;
    logic [PRICE_W-1:0]      r_out_mean, n_out_mean;
    logic                    r_out_done, n_out_done;

    // ---------------- shared multiplier ----------------
    logic               w_mul_start, w_mul_done;
    logic [OPD_W-1:0]   w_mul_a, w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [X_W-1:0]     w_xmag;
    logic [RES_W-1:0]   w_resmag;

    assign w_xmag      = r_x[X_W-1] ? X_W'(-r_x) : X_W'(r_x);
    assign w_resmag    = r_res[RES_W-1] ? RES_W'(-r_res) : RES_W'(r_res);
    assign w_mul_start = (r_state == ST_ISSUE);

    // operand select per slot
    always_comb begin
        case (r_op)
            OP_EXPONENT: begin
                w_mul_a = {{(OPD_W-VOL_W){1'b0}}, r_vol};
                w_mul_b = {{(OPD_W-Z_W){1'b0}}, r_zmag};
            end
            OP_PRICE: begin
                w_mul_a = {{(OPD_W-PRICE_W){1'b0}},
                           (r_day == '0) ? r_start_price : r_price};
                w_mul_b = OPD_W'(r_res);
            end
            default: begin
                w_mul_a = {{(OPD_W-X_W){1'b0}}, w_xmag};
                w_mul_b = {{(OPD_W-RES_W){1'b0}}, w_resmag};
            end
        endcase
    end

    gbmps_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // ---------------- mean divider ----------------
    logic               w_div_start, w_div_done;
    logic [SUM_W-1:0]   w_quot;
    logic [PRICE_W-1:0] w_mean_sat;

    assign w_div_start = (r_state == ST_DIV_START);
    assign w_mean_sat  = (|w_quot[SUM_W-1:PRICE_W]) ? PRICE_MAX : w_quot[PRICE_W-1:0];

    gbmps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (w_paths_c),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // ---------------- post-product arithmetic ----------------
    // exponent: vol*z scaled to Q.30 toward zero, plus drift, clamped to +-16
    localparam int PMAG_W = VOL_W + Z_W - Z_FRAC;

    logic [PMAG_W-1:0]         w_pmag;
    logic signed [PMAG_W+1:0]  w_pterm, w_x_sum;
    logic signed [X_W-1:0]     w_x_new;

    assign w_pmag  = w_prod[VOL_W+Z_W-1:Z_FRAC];
    assign w_pterm = r_zneg ? -$signed({2'b00, w_pmag}) : $signed({2'b00, w_pmag});
    assign w_x_sum = w_pterm + (PMAG_W+2)'(r_drift);

    always_comb begin
        if (w_x_sum > (PMAG_W+2)'(EXP_LIMIT)) begin
            w_x_new = EXP_LIMIT;
        end else if (w_x_sum < -(PMAG_W+2)'(EXP_LIMIT)) begin
            w_x_new = -EXP_LIMIT;
        end else begin
            w_x_new = X_W'(w_x_sum);
        end
    end

    // Horner step: signed Q.30 product truncated toward zero, plus coefficient
    logic [RES_W-1:0]        w_hmag;
    logic                    w_hneg;
    logic signed [RES_W-1:0] w_hterm, w_res_new;

    assign w_hmag    = w_prod[RES_W+Q_FRAC-1:Q_FRAC];
    assign w_hneg    = r_x[X_W-1] ^ r_res[RES_W-1];
    assign w_hterm   = w_hneg ? -$signed(w_hmag) : $signed(w_hmag);
    assign w_res_new = w_hterm + horner_coef(r_op);

    // price update with saturation
    logic [PROD_W-Q_FRAC-1:0] w_pq;
    logic [PRICE_W-1:0]       w_price_new;

    assign w_pq        = w_prod[PROD_W-1:Q_FRAC];
    assign w_price_new = (|w_pq[PROD_W-Q_FRAC-1:PRICE_W]) ? PRICE_MAX : w_pq[PRICE_W-1:0];

    // ---------------- path bookkeeping ----------------
    logic [DAY_CNT_W:0]  w_day_inc;
    logic [PATH_CNT_W:0] w_path_inc;
    logic                w_last_day, w_last_path;
    logic [SUM_W:0]      w_sum_ext;

    assign w_day_inc   = {1'b0, r_day} + 1'b1;
    assign w_path_inc  = {1'b0, r_path} + 1'b1;
    assign w_last_day  = ((DAYS_W)'(w_day_inc) >= w_days_c);
    assign w_last_path = ((PATHS_W)'(w_path_inc) >= w_paths_c);
    assign w_sum_ext   = {1'b0, r_sum} + {{(SUM_W-PRICE_W+1){1'b0}}, r_price};

    logic w_in_acc, w_out_free;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------- next state ----------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_zmag      = r_zmag;
        n_zneg      = r_zneg;
        n_x         = r_x;
        n_res       = r_res;
        n_price     = r_price;
        n_day       = r_day;
        n_path      = r_path;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        n_run_end   = r_run_end;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_final = r_out_final;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        n_out_mean  = r_out_mean;
        n_out_done  = r_out_done;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_zneg  = i_normal_sample[Z_W-1];
                    n_zmag  = i_normal_sample[Z_W-1] ? Z_W'(-i_normal_sample)
                                                     : Z_W'(i_normal_sample);
                    n_op    = OP_EXPONENT;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_mul_done) begin
                    case (r_op)
                        OP_EXPONENT: begin
                            n_x   = w_x_new;
                            n_res = horner_coef(OP_EXPONENT);
                        end
                        OP_PRICE: begin
                            n_price = w_price_new;
                        end
                        OP_LAST_HORNER: begin
                            // exp result is clamped at zero from below
                            n_res = w_res_new[RES_W-1] ? '0 : w_res_new;
                        end
                        default: begin
                            n_res = w_res_new;
                        end
                    endcase
                    if (r_op == OP_PRICE) begin
                        n_state = ST_DAY_END;
                    end else begin
                        n_op    = r_op + 3'd1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_DAY_END: begin
                if (!w_last_day) begin
                    n_day   = w_day_inc[DAY_CNT_W-1:0];
                    n_state = ST_IDLE;
                end else begin
                    n_day     = '0;
                    n_min     = (r_price < r_min) ? r_price : r_min;
                    n_max     = (r_price > r_max) ? r_price : r_max;
                    n_sum     = (w_sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX
                                                               : w_sum_ext[SUM_W-1:0];
                    n_path    = w_path_inc[PATH_CNT_W-1:0];
                    n_run_end = w_last_path;
                    n_state   = w_last_path ? ST_DIV_START : ST_OUT;
                end
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_final = r_price;
                    n_out_low   = r_min;
                    n_out_high  = r_max;
                    n_out_mean  = r_run_end ? w_mean_sat : '0;
                    n_out_done  = r_run_end;
                    if (r_run_end) begin
                        // start a fresh run
                        n_min  = PRICE_MAX;
                        n_max  = '0;
                        n_sum  = '0;
                        n_path = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_EXPONENT;
            r_price     <= '0;
            r_day       <= '0;
            r_path      <= '0;
            r_min       <= PRICE_MAX;
            r_max       <= '0;
            r_sum       <= '0;
            r_run_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_price     <= n_price;
            r_day       <= n_day;
            r_path      <= n_path;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_run_end   <= n_run_end;
            r_out_valid <= n_out_valid;
        end
        r_zmag      <= n_zmag;
        r_zneg      <= n_zneg;
        r_x         <= n_x;
        r_res       <= n_res;
        r_out_final <= n_out_final;
        r_out_low   <= n_out_low;
        r_out_high  <= n_out_high;
        r_out_mean  <= n_out_mean;
        r_out_done  <= n_out_done;
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_final_price   = r_out_final;
    assign o_lowest_price  = r_out_low;
    assign o_highest_price = r_out_high;
    assign o_mean_price    = r_out_mean;
    assign o_run_done      = r_out_done;

endmodule

`default_nettype wire

>>> design/gbmps_chk.sv
// gbmps_chk: port-level checks on the simulator's channels, bound to the
// top level. Depends on gbmps_pkg and gbm_path_price_simulator.
`default_nettype none

module gbmps_chk import gbmps_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [PRICE_W-1:0] o_final_price,
    input wire logic [PRICE_W-1:0] o_lowest_price,
    input wire logic [PRICE_W-1:0] o_highest_price,
    input wire logic [PRICE_W-1:0] o_mean_price,
    input wire logic               o_run_done
);

    // a stalled result stays valid and its final price holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_final_price))
        else $error("stalled result changed");

    // an accepted request keeps the sequencer busy in the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepted request");

    // final price lies between the running minimum and maximum
    a_final_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lowest_price <= o_final_price) &&
                        (o_final_price <= o_highest_price))
        else $error("final price outside min/max");

    // mean is only reported at the end of a run
    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_done |-> o_mean_price == '0)
        else $error("mean reported before run end");

endmodule

bind gbm_path_price_simulator gbmps_chk u_chk (.*);

`default_nettype wire
